/* src/clwc_pkg.sv */
package clwc_pkg;

    localparam int TIME_WIDTH      = 32;
    localparam int COORD_FRAC_BITS = 4;
    localparam int PAIR_COUNT      = 56;
    localparam int FIFO_DEPTH      = 4;
    localparam int FIFO_PTR_W      = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W      = $clog2(FIFO_DEPTH + 1);

    // register indexes on the config port
    localparam logic [2:0] REG_MODULE_SEPARATION = 3'd0;
    localparam logic [2:0] REG_MODULE_HEIGHT     = 3'd1;
    localparam logic [2:0] REG_SEGMENT_HEIGHT    = 3'd2;
    localparam logic [2:0] REG_SEGMENT_WIDTH     = 3'd3;
    localparam logic [2:0] REG_BLOCK_WIDTH       = 3'd4;
    localparam logic [2:0] REG_BLOCK_GAP         = 3'd5;
    localparam logic [2:0] REG_MAX_MODULE_PAIR   = 3'd6;

    // reset geometry in output LSB units
    localparam logic [15:0] SEP_RESET  = 16'((250 << COORD_FRAC_BITS) & 16'hFFFF);
    localparam logic [15:0] MODH_RESET = 16'((95 << COORD_FRAC_BITS) & 16'hFFFF);
    localparam logic [15:0] SEGH_RESET = 16'(((27 << COORD_FRAC_BITS) >> 1) & 16'hFFFF);
    localparam logic [15:0] SEGW_RESET = 16'(((25 << COORD_FRAC_BITS) >> 2) & 16'hFFFF);
    localparam logic [15:0] BLKW_RESET = 16'((50 << COORD_FRAC_BITS) & 16'hFFFF);
    localparam logic [15:0] GAP_RESET  = 16'((41 << COORD_FRAC_BITS) & 16'hFFFF);
    localparam logic [5:0]  MAXP_RESET = 6'd28;

    localparam logic signed [23:0] COORD_MAX = 24'sd524287;
    localparam logic signed [23:0] COORD_MIN = -24'sd524288;

    // high nibble first bucket, low nibble second bucket
    localparam logic [7:0] PAIR_TABLE [PAIR_COUNT] = '{
        8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0A, 8'h0B,
        8'h16, 8'h17, 8'h18, 8'h19, 8'h1A, 8'h1B, 8'h1C,
        8'h27, 8'h28, 8'h29, 8'h2A, 8'h2B, 8'h2C, 8'h2D,
        8'h38, 8'h39, 8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E,
        8'h49, 8'h4A, 8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h4F,
        8'h5A, 8'h5B, 8'h5C, 8'h5D, 8'h5E, 8'h5F,
        8'h6B, 8'h6C, 8'h6D, 8'h6E, 8'h6F,
        8'h7C, 8'h7D, 8'h7E, 8'h7F,
        8'h8D, 8'h8E, 8'h8F,
        8'h9E, 8'h9F,
        8'hAF
    };

    typedef struct packed {
        logic [15:0] module_separation;
        logic [15:0] module_height;
        logic [15:0] segment_height;
        logic [15:0] segment_width;
        logic [15:0] block_width;
        logic [15:0] block_gap;
    } geom_cfg_t;

    typedef struct packed {
        logic [4:0] bucket;
        logic [1:0] block;
        logic [2:0] seg;
        logic [1:0] plane;
    } det_fields_t;

    // one classified word, front to back
    typedef struct packed {
        logic        valid;
        logic [3:0]  tag;
        logic [31:0] time_lo;
        det_fields_t det0;
        det_fields_t det1;
    } fe_rec_t;

    typedef struct packed {
        logic              known;
        logic signed [19:0] x;
        logic signed [19:0] y;
        logic signed [19:0] z;
    } det_coord_t;

    typedef struct packed {
        logic        valid;
        logic [3:0]  tag;
        logic [31:0] time_lo;
        det_coord_t  first;
        det_coord_t  second;
    } result_t;

    function automatic logic signed [19:0] sat20(input logic signed [23:0] v);
        logic signed [19:0] r;
        if (v > COORD_MAX)
            r = COORD_MAX[19:0];
        else if (v < COORD_MIN)
            r = COORD_MIN[19:0];
        else
            r = v[19:0];
        return r;
    endfunction

endpackage

/* src/clwc_front.sv */
module clwc_front
    import clwc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic [5:0]  max_module_pair,
    input  logic        q_full,
    output logic        q_push,
    output fe_rec_t     q_rec
);

    logic [3:0]            last_tag_reg, last_tag_next;
    logic [TIME_WIDTH-1:0] running_time_reg, running_time_next;
    logic [15:0]           word_a, word_b;
    logic [3:0]            tag, dt;
    logic [5:0]            pair, limit, tbl_idx;
    logic [7:0]            entry;
    logic                  pair_ok;
    logic [31:0]           time_low;

    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            word_a[i] = s_tdata[15 - i];
            word_b[i] = s_tdata[31 - i];
        end
    end

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    assign tag    = word_b[3:0];
    assign dt     = tag - last_tag_reg;
    assign pair   = word_a[5:0];
    assign limit  = (max_module_pair > 6'(PAIR_COUNT)) ? 6'(PAIR_COUNT) : max_module_pair;
    assign pair_ok = (pair != 6'd0) && (pair <= limit);
    assign tbl_idx = pair - 6'd1;
    assign entry   = (tbl_idx < 6'(PAIR_COUNT)) ? PAIR_TABLE[tbl_idx] : 8'd0;

    assign last_tag_next     = q_push ? tag : last_tag_reg;
    assign running_time_next = q_push
        ? running_time_reg + TIME_WIDTH'({dt, 1'b0})
        : running_time_reg;
    assign time_low = 32'(running_time_next);

    always_comb
    begin
        q_rec.valid       = pair_ok;
        q_rec.tag         = pair_ok ? tag : 4'd0;
        q_rec.time_lo     = pair_ok ? time_low : 32'd0;
        q_rec.det0.bucket = {word_a[14], entry[7:4]};
        q_rec.det0.block  = word_b[8:7];
        q_rec.det0.seg    = word_b[12:10];
        q_rec.det0.plane  = word_a[9:8];
        q_rec.det1.bucket = {word_a[15], entry[3:0]};
        q_rec.det1.block  = word_b[14:13];
        q_rec.det1.seg    = word_b[6:4];
        q_rec.det1.plane  = word_a[12:11];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_tag_reg     <= '0;
            running_time_reg <= '0;
        end
        else
        begin
            last_tag_reg     <= last_tag_next;
            running_time_reg <= running_time_next;
        end
    end

    // time only ever advances by even steps
    a_time_even: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |=> running_time_reg[0] == $past(running_time_reg[0]))
        else $error("running time lsb changed");

endmodule

/* src/clwc_fifo.sv */
module clwc_fifo
    import clwc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  fe_rec_t wr_rec,
    output logic    full,
    input  logic    pop,
    output logic    rd_valid,
    output fe_rec_t rd_rec
);

    fe_rec_t               slot_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;
    logic                  do_pop;

    assign full     = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_rec   = slot_reg[rd_ptr_reg];
    assign do_pop   = pop && rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1))
                        ? '0 : wr_ptr_reg + FIFO_PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1))
                        ? '0 : rd_ptr_reg + FIFO_PTR_W'(1);
        if (push && !do_pop)
            count_next = count_reg + FIFO_CNT_W'(1);
        else if (do_pop && !push)
            count_next = count_reg - FIFO_CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= wr_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("queue count out of range");

endmodule

/* src/clwc_back.sv */
module clwc_back
    import clwc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  geom_cfg_t cfg,
    input  logic      q_valid,
    input  fe_rec_t   q_rec,
    output logic      q_pop,
    output logic      out_valid,
    input  logic      out_ready,
    output result_t   out_res
);

    typedef struct packed {
        logic               known;
        logic [1:0]         face;
        logic signed [22:0] lat_part;
        logic [18:0]        seg_prod;
        logic [17:0]        h_a;
        logic [17:0]        h_b;
    } s1_det_t;

    typedef struct packed {
        logic        valid;
        logic [3:0]  tag;
        logic [31:0] time_lo;
        s1_det_t     det0;
        s1_det_t     det1;
    } s1_rec_t;

    s1_rec_t    s1_reg, s1_next;
    logic       s1_valid_reg;
    result_t    out_reg, out_next;
    logic       out_valid_reg;
    logic       out_load, s1_load;
    det_coord_t coord0, coord1;

    function automatic s1_det_t stage1(input det_fields_t d, input geom_cfg_t c);
        s1_det_t            r;
        logic [16:0]        pitch;
        logic signed [22:0] term;
        pitch = {1'b0, c.block_width} + {1'b0, c.block_gap};
        case (d.block)
            2'd0: term = signed'({4'b0, pitch, 2'b0});
            2'd1: term = signed'({5'b0, pitch, 1'b0});
            2'd2: term = '0;
            2'd3: term = -signed'({5'b0, pitch, 1'b0});
            default: term = '0;
        endcase
        r.known    = !d.bucket[2];
        r.face     = d.bucket[4:3];
        r.lat_part = term - signed'({7'b0, c.block_gap}) - signed'({7'b0, c.segment_width});
        r.seg_prod = {16'b0, 3'(3'd7 - d.seg)} * {3'b0, c.segment_width};
        r.h_a      = {16'b0, 2'(2'd3 - d.bucket[1:0])} * {2'b0, c.module_height};
        r.h_b      = {16'b0, d.plane} * {2'b0, c.segment_height};
        return r;
    endfunction

    function automatic det_coord_t stage2(input s1_det_t d, input logic ok,
                                          input logic [15:0] sep);
        det_coord_t         r;
        logic signed [22:0] lat, lat_h;
        logic signed [23:0] l24, s24, h24, x, z;
        lat   = d.lat_part - signed'({3'b0, d.seg_prod, 1'b0});
        lat_h = lat >>> 1;                       // floor of half
        l24   = {lat_h[22], lat_h};
        s24   = signed'({8'b0, sep});
        h24   = signed'({6'b0, d.h_a} + {6'b0, d.h_b});
        case (d.face)
            2'd0:    begin x = s24;  z = l24;  end
            2'd1:    begin x = -s24; z = -l24; end
            2'd2:    begin x = l24;  z = -s24; end
            2'd3:    begin x = -l24; z = s24;  end
            default: begin x = '0;   z = '0;   end
        endcase
        if (ok && d.known)
        begin
            r.known = 1'b1;
            r.x     = sat20(x);
            r.y     = sat20(h24);
            r.z     = sat20(z);
        end
        else
            r = '0;
        return r;
    endfunction

    // each stage moves when the one after it is free or moving
    assign out_load = !out_valid_reg || out_ready;
    assign s1_load  = !s1_valid_reg || out_load;
    assign q_pop    = s1_load && q_valid;

    always_comb
    begin
        s1_next.valid   = q_rec.valid;
        s1_next.tag     = q_rec.tag;
        s1_next.time_lo = q_rec.time_lo;
        s1_next.det0    = stage1(q_rec.det0, cfg);
        s1_next.det1    = stage1(q_rec.det1, cfg);
    end

    assign coord0 = stage2(s1_reg.det0, s1_reg.valid, cfg.module_separation);
    assign coord1 = stage2(s1_reg.det1, s1_reg.valid, cfg.module_separation);

    always_comb
    begin
        out_next.valid   = s1_reg.valid;
        out_next.tag     = s1_reg.tag;
        out_next.time_lo = s1_reg.time_lo;
        out_next.first   = coord0;
        out_next.second  = coord1;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            s1_reg <= s1_next;
        if (out_load && s1_valid_reg)
            out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_load)
                s1_valid_reg <= q_valid;
            if (out_load)
                out_valid_reg <= s1_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_reg.valid |-> out_reg == '0)
        else $error("rejected word carries nonzero fields");

    a_known_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_reg.first.known || out_reg.second.known) |-> out_reg.valid)
        else $error("detector known on rejected word");

endmodule

/* src/coincidence_word_to_lor_coords.sv */
// Coincidence word decoder: raw 32-bit camera words in, two detector positions out.
// Path: a result reaches m_tvalid through the queue, the stage 1 register and
//   the output register. One word per cycle while the queue has room; the back end
//   drains one queue entry per cycle while the output is not stalled.
// Reset (rst_n, async, active low) clears time tag history, running time, queue and
//   pipeline valids, and loads the default geometry registers.
module coincidence_word_to_lor_coords
    import clwc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // [31:0] event_word
    // output stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [159:0] m_tdata,   // tag_out, time_out, first_x/y/z, second_x/y/z, pad
    output logic [2:0]   m_tuser,   // event_valid, first_known, second_known
    // configuration writes
    input  logic         cfg_we,
    input  logic [2:0]   cfg_addr,
    input  logic [15:0]  cfg_wdata
);

    geom_cfg_t cfg_reg;
    logic [5:0] max_pair_reg;

    fe_rec_t push_rec, pop_rec;
    logic    q_push, q_full, q_pop, q_valid;
    result_t res;

    // Geometry registers. Writes must come only while the block is idle; the block does
    // not enforce this. Both ends read them live without shadowing.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.module_separation <= SEP_RESET;
            cfg_reg.module_height     <= MODH_RESET;
            cfg_reg.segment_height    <= SEGH_RESET;
            cfg_reg.segment_width     <= SEGW_RESET;
            cfg_reg.block_width       <= BLKW_RESET;
            cfg_reg.block_gap         <= GAP_RESET;
            max_pair_reg              <= MAXP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_MODULE_SEPARATION: cfg_reg.module_separation <= cfg_wdata;
                REG_MODULE_HEIGHT:     cfg_reg.module_height     <= cfg_wdata;
                REG_SEGMENT_HEIGHT:    cfg_reg.segment_height    <= cfg_wdata;
                REG_SEGMENT_WIDTH:     cfg_reg.segment_width     <= cfg_wdata;
                REG_BLOCK_WIDTH:       cfg_reg.block_width       <= cfg_wdata;
                REG_BLOCK_GAP:         cfg_reg.block_gap         <= cfg_wdata;
                REG_MAX_MODULE_PAIR:   max_pair_reg              <= cfg_wdata[5:0];
                default: ;  // unknown index, write dropped
            endcase
        end
    end

    // Front: bit-reverse halves, advance running time, look up the bucket pair,
    // reject out-of-range pairs. Every transfer pushes one record.
    clwc_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .max_module_pair (max_pair_reg),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_rec           (push_rec)
    );

    // Short queue so an output stall does not stop the front until it fills.
    clwc_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .wr_rec   (push_rec),
        .full     (q_full),
        .pop      (q_pop),
        .rd_valid (q_valid),
        .rd_rec   (pop_rec)
    );

    // Back: products and block offsets in stage 1; the remaining sums, halving,
    // face select and saturation in stage 2 feeding the output register.
    clwc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_rec     (pop_rec),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    // tdata, lsb up: tag_out[3:0], time_out[35:4], first_x[55:36], first_y[75:56],
    // first_z[95:76], second_x[115:96], second_y[135:116], second_z[155:136], zero pad
    assign m_tdata = {4'b0,
                      res.second.z, res.second.y, res.second.x,
                      res.first.z, res.first.y, res.first.x,
                      res.time_lo, res.tag};
    // tuser, lsb up: event_valid, first_known, second_known
    assign m_tuser = {res.second.known, res.first.known, res.valid};

endmodule

/* dv/lor_coord_checker.sv */
module lor_coord_checker
    import clwc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [31:0]  s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [159:0] m_tdata,
    input  logic [2:0]   m_tuser,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_addr,
    input  logic [15:0]  cfg_wdata,
    output int           outstanding,
    output int           fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint COORD_TOP    = 524287;
    localparam longint COORD_BOTTOM = -524288;

    // face codes: bucket[4:3]
    localparam logic [1:0] FACE_XPOS = 2'd0;
    localparam logic [1:0] FACE_XNEG = 2'd1;
    localparam logic [1:0] FACE_ZNEG = 2'd2;
    localparam logic [1:0] FACE_ZPOS = 2'd3;

    // module pair -> {first bucket, second bucket}
    localparam logic [7:0] BUCKET_PAIRS [56] = '{
        8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0A, 8'h0B,
        8'h16, 8'h17, 8'h18, 8'h19, 8'h1A, 8'h1B, 8'h1C,
        8'h27, 8'h28, 8'h29, 8'h2A, 8'h2B, 8'h2C, 8'h2D,
        8'h38, 8'h39, 8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E,
        8'h49, 8'h4A, 8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h4F,
        8'h5A, 8'h5B, 8'h5C, 8'h5D, 8'h5E, 8'h5F,
        8'h6B, 8'h6C, 8'h6D, 8'h6E, 8'h6F,
        8'h7C, 8'h7D, 8'h7E, 8'h7F,
        8'h8D, 8'h8E, 8'h8F,
        8'h9E, 8'h9F,
        8'hAF
    };

    typedef struct packed {
        logic               valid;
        logic [3:0]         tag;
        logic [31:0]        stamp;
        logic signed [19:0] fx;
        logic signed [19:0] fy;
        logic signed [19:0] fz;
        logic               fk;
        logic signed [19:0] sx;
        logic signed [19:0] sy;
        logic signed [19:0] sz;
        logic               sk;
    } lor_t;

    // geometry copy
    logic [15:0] sep_len, mod_pitch, plane_pitch, seg_pitch, blk_len, gap_len;
    logic [5:0]  pair_max;
    // timing state
    logic [3:0]  prev_tag;
    logic [31:0] run_clock;

    lor_t expected_lor_q [$];
    int   fails = 0;

    function automatic logic [15:0] unmirror16(input logic [15:0] v);
        logic [15:0] r;
        for (int i = 0; i < 16; i++)
            r[15 - i] = v[i];
        return r;
    endfunction

    function automatic logic signed [19:0] clamp20(input longint v);
        if (v > COORD_TOP)
            return COORD_TOP[19:0];
        if (v < COORD_BOTTOM)
            return COORD_BOTTOM[19:0];
        return v[19:0];
    endfunction

    function automatic void face_position(input logic [4:0] bucket, input logic [1:0] blk,
                                          input logic [2:0] seg, input logic [1:0] plane,
                                          output logic signed [19:0] x,
                                          output logic signed [19:0] y,
                                          output logic signed [19:0] z,
                                          output logic known);
        longint sep, bw, gp, sw, mh, sh, bl, sg, pl, bq, lat, h;
        x = '0;
        y = '0;
        z = '0;
        known = 1'b0;
        if (bucket[2])
            return;
        sep = longint'(sep_len);
        bw  = longint'(blk_len);
        gp  = longint'(gap_len);
        sw  = longint'(seg_pitch);
        mh  = longint'(mod_pitch);
        sh  = longint'(plane_pitch);
        bl  = longint'(blk);
        sg  = longint'(seg);
        pl  = longint'(plane);
        bq  = longint'(bucket[1:0]);
        lat = 2 * (2 - bl) * (bw + gp) - gp - sw - 2 * (7 - sg) * sw;
        lat = lat >>> 1;    // floor, before any negation
        h   = (3 - bq) * mh + pl * sh;
        case (bucket[4:3])
            FACE_XPOS: begin x = clamp20(sep);  z = clamp20(lat);  end
            FACE_XNEG: begin x = clamp20(-sep); z = clamp20(-lat); end
            FACE_ZNEG: begin x = clamp20(lat);  z = clamp20(-sep); end
            FACE_ZPOS: begin x = clamp20(-lat); z = clamp20(sep);  end
            default:   begin x = '0;            z = '0;            end
        endcase
        y = clamp20(h);
        known = 1'b1;
    endfunction

    // advances tag/time state and returns the expected result
    function automatic lor_t decode_coincidence(input logic [31:0] w);
        lor_t        r;
        logic [15:0] a, b;
        logic [3:0]  tag, dt;
        logic [5:0]  pair, lim;
        logic [7:0]  entry;
        logic [4:0]  bk0, bk1;
        r = '0;
        a = unmirror16(w[15:0]);
        b = unmirror16(w[31:16]);
        tag = b[3:0];
        dt = tag - prev_tag;
        run_clock = run_clock + {27'd0, dt, 1'b0};
        prev_tag = tag;
        pair = a[5:0];
        lim = (pair_max > 6'd56) ? 6'd56 : pair_max;
        if (pair == 6'd0 || pair > lim)
            return r;
        entry = BUCKET_PAIRS[pair - 6'd1];
        bk0 = {1'b0, entry[7:4]} + (a[14] ? 5'd16 : 5'd0);
        bk1 = {1'b0, entry[3:0]} + (a[15] ? 5'd16 : 5'd0);
        r.valid = 1'b1;
        r.tag = tag;
        r.stamp = run_clock;
        face_position(bk0, b[8:7], b[12:10], a[9:8], r.fx, r.fy, r.fz, r.fk);
        face_position(bk1, b[14:13], b[6:4], a[12:11], r.sx, r.sy, r.sz, r.sk);
        return r;
    endfunction

    function automatic void match_field(input string name, input longint want,
                                        input longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin : track
        lor_t want, seen;
        if (!rst_n) begin
            sep_len     = 16'd4000;
            mod_pitch   = 16'd1520;
            plane_pitch = 16'd216;
            seg_pitch   = 16'd100;
            blk_len     = 16'd800;
            gap_len     = 16'd656;
            pair_max    = 6'd28;
            prev_tag    = '0;
            run_clock   = '0;
            expected_lor_q.delete();
            outstanding <= 0;
            fail_count  <= fails;
        end
        else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_MODULE_SEPARATION: sep_len     = cfg_wdata;
                    REG_MODULE_HEIGHT:     mod_pitch   = cfg_wdata;
                    REG_SEGMENT_HEIGHT:    plane_pitch = cfg_wdata;
                    REG_SEGMENT_WIDTH:     seg_pitch   = cfg_wdata;
                    REG_BLOCK_WIDTH:       blk_len     = cfg_wdata;
                    REG_BLOCK_GAP:         gap_len     = cfg_wdata;
                    REG_MAX_MODULE_PAIR:   pair_max    = cfg_wdata[5:0];
                    default: ;
                endcase
            end
            // pop before push: a stray result must not claim a word taken this cycle
            if (m_tvalid && m_tready) begin
                seen.valid = m_tuser[0];
                seen.fk    = m_tuser[1];
                seen.sk    = m_tuser[2];
                seen.tag   = m_tdata[3:0];
                seen.stamp = m_tdata[35:4];
                seen.fx    = m_tdata[55:36];
                seen.fy    = m_tdata[75:56];
                seen.fz    = m_tdata[95:76];
                seen.sx    = m_tdata[115:96];
                seen.sy    = m_tdata[135:116];
                seen.sz    = m_tdata[155:136];
                if (expected_lor_q.size() == 0) begin
                    $error("output transfer with no word outstanding");
                    fails++;
                end
                else begin
                    want = expected_lor_q.pop_front();
                    match_field("event_valid",  longint'(want.valid), longint'(seen.valid));
                    match_field("tag_out",      longint'(want.tag),   longint'(seen.tag));
                    match_field("time_out",     longint'(want.stamp), longint'(seen.stamp));
                    match_field("first_x",      longint'(want.fx),    longint'(seen.fx));
                    match_field("first_y",      longint'(want.fy),    longint'(seen.fy));
                    match_field("first_z",      longint'(want.fz),    longint'(seen.fz));
                    match_field("first_known",  longint'(want.fk),    longint'(seen.fk));
                    match_field("second_x",     longint'(want.sx),    longint'(seen.sx));
                    match_field("second_y",     longint'(want.sy),    longint'(seen.sy));
                    match_field("second_z",     longint'(want.sz),    longint'(seen.sz));
                    match_field("second_known", longint'(want.sk),    longint'(seen.sk));
                end
            end
            if (s_tvalid && s_tready)
                expected_lor_q.push_back(decode_coincidence(s_tdata));
            outstanding <= expected_lor_q.size();
            fail_count  <= fails;
        end
    end

endmodule

/* dv/testbench.sv */
module testbench;
    import clwc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // index past the register file; writes there must be dropped
    localparam logic [2:0] REG_UNUSED = 3'd7;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [31:0]  s_tdata;     // [31:0] event_word
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // [3:0] tag_out, [35:4] time_out, [55:36] first_x, [75:56] first_y,
    // [95:76] first_z, [115:96] second_x, [135:116] second_y,
    // [155:136] second_z, [159:156] zero pad
    logic [159:0] m_tdata;
    // [0] event_valid, [1] first_known, [2] second_known
    logic [2:0]   m_tuser;
    logic         cfg_we;
    logic [2:0]   cfg_addr;
    logic [15:0]  cfg_wdata;

    int outstanding;
    int fail_count;

    // stimulus bookkeeping
    int         words_sent;
    int         settings_used;
    logic [5:0] pair_limit;      // effective pair limit, clipped to table size
    logic       calm;            // no idling on either side once set
    logic       squeeze_req;     // asks the sink for one long hold-off
    logic       squeeze_done = 1'b0;
    int         sink_wait = 0;

    coincidence_word_to_lor_coords dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    lor_coord_checker lor_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .outstanding (outstanding),
        .fail_count  (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // hard stop well past the slowest legal run
    initial
    begin
        #5000000;
        $display("FAIL");
        $finish;
    end

    // Sink side. Random hold-off bursts; one long stretch on request so the
    // queue fills up and the block drops s_tready while the source keeps
    // offering words.
    always @(posedge clk)
    begin
        if (sink_wait > 0)
        begin
            m_tready  <= 1'b0;
            sink_wait <= sink_wait - 1;
        end
        else if (squeeze_req && !squeeze_done)
        begin
            m_tready     <= 1'b0;
            sink_wait    <= 80;
            squeeze_done <= 1'b1;
        end
        else if (!calm && $urandom_range(0, 9) == 0)
        begin
            m_tready  <= 1'b0;
            sink_wait <= $urandom_range(0, 10);
        end
        else
            m_tready <= 1'b1;
    end

    // the block bit-reverses each half of the word, so build the halves
    // in decoded order and mirror them on the way in
    function automatic logic [15:0] flip16(input logic [15:0] v);
        logic [15:0] r;
        for (int i = 0; i < 16; i++)
            r[15 - i] = v[i];
        return r;
    endfunction

    // low half after reversal: pair, planes, bucket +16 flags
    function automatic logic [15:0] half_a(input int pair, input int p0,
                                           input int p1, input int hi0,
                                           input int hi1);
        return {1'(hi1), 1'(hi0), 1'b0, 2'(p1), 1'b0, 2'(p0), 2'b00, 6'(pair)};
    endfunction

    // high half after reversal: tag, blocks, segments
    function automatic logic [15:0] half_b(input int tag, input int blk0,
                                           input int seg0, input int blk1,
                                           input int seg1);
        return {1'b0, 2'(blk1), 3'(seg0), 1'b0, 2'(blk0), 3'(seg1), 4'(tag)};
    endfunction

    // One word transfer. valid stays high into the next call unless a
    // random source gap is taken right after the transfer.
    task automatic send_word(input logic [31:0] w);
        s_tdata  <= w;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        words_sent++;
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
    endtask

    task automatic send_ab(input logic [15:0] a, input logic [15:0] b);
        send_word({flip16(b), flip16(a)});
    endtask

    // source pause until every result is back, plus pipeline slack
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // full register set, written back to back only while the block is idle
    task automatic program_regs(input logic [15:0] sep, input logic [15:0] mh,
                                input logic [15:0] sh, input logic [15:0] sw,
                                input logic [15:0] bw, input logic [15:0] gap,
                                input logic [15:0] maxp_word, input bit stray);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_MODULE_SEPARATION;
        cfg_wdata <= sep;
        @(posedge clk);
        cfg_addr  <= REG_MODULE_HEIGHT;
        cfg_wdata <= mh;
        @(posedge clk);
        cfg_addr  <= REG_SEGMENT_HEIGHT;
        cfg_wdata <= sh;
        @(posedge clk);
        cfg_addr  <= REG_SEGMENT_WIDTH;
        cfg_wdata <= sw;
        @(posedge clk);
        cfg_addr  <= REG_BLOCK_WIDTH;
        cfg_wdata <= bw;
        @(posedge clk);
        cfg_addr  <= REG_BLOCK_GAP;
        cfg_wdata <= gap;
        @(posedge clk);
        // only the low 6 bits count; some callers put junk in the upper bits on purpose
        cfg_addr  <= REG_MAX_MODULE_PAIR;
        cfg_wdata <= maxp_word;
        @(posedge clk);
        if (stray)
        begin
            cfg_addr  <= REG_UNUSED;
            cfg_wdata <= 16'($urandom_range(0, 65535));
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        pair_limit = (maxp_word[5:0] > PAIR_COUNT) ? 6'(PAIR_COUNT) : maxp_word[5:0];
        settings_used++;
    endtask

    // Random words. Most have pair in 1..limit (1..56 if the limit is zero) and
    // every other bit random, some have pair zero or above the limit, the rest raw.
    task automatic run_random(input int count, input int squeeze_at);
        int          pick;
        logic [15:0] a, b;
        for (int k = 0; k < count; k++)
        begin
            if (k == squeeze_at)
                squeeze_req <= 1'b1;
            pick = $urandom_range(0, 99);
            a = 16'($urandom_range(0, 65535));
            b = 16'($urandom_range(0, 65535));
            if (pick < 75)
                a[5:0] = (pair_limit != 0) ? 6'($urandom_range(1, pair_limit))
                                           : 6'($urandom_range(1, PAIR_COUNT));
            else if (pick < 85)
                a[5:0] = ($urandom_range(0, 1) == 0)
                       ? 6'd0 : 6'($urandom_range(int'(pair_limit) + 1, 63));
            if (pick < 85)
                send_ab(a, b);
            else
                send_word($urandom);
        end
    endtask

    initial
    begin : stimulus
        int span;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        cfg_we        = 1'b0;
        cfg_addr      = '0;
        cfg_wdata     = '0;
        calm          = 1'b0;
        squeeze_req   = 1'b0;
        words_sent    = 0;
        settings_used = 1;
        pair_limit    = 6'd28;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words on the reset geometry
        send_ab(half_a(0, 0, 0, 0, 0), half_b(0, 0, 0, 0, 0));       // pair zero
        send_word(32'hFFFF_FFFF);                                    // pair 63, tag 15
        send_ab(half_a(1, 0, 0, 0, 0), half_b(0, 0, 0, 0, 0));       // tag drop wraps
        send_ab(half_a(1, 0, 3, 0, 0), half_b(15, 0, 0, 3, 7));      // second off-face
        send_ab(half_a(22, 1, 2, 0, 1), half_b(3, 1, 4, 2, 1));      // tag 15 -> 3 wraps
        send_ab(half_a(28, 3, 3, 1, 1), half_b(3, 2, 5, 1, 6));      // same tag, top pair
        send_ab(half_a(28, 0, 0, 0, 0), half_b(0, 0, 0, 0, 0));
        send_ab(half_a(29, 1, 1, 0, 0), half_b(9, 1, 1, 1, 1));      // just past limit
        send_ab(half_a(8, 2, 1, 0, 0), half_b(12, 3, 2, 0, 5));
        send_ab(half_a(16, 3, 0, 1, 0), half_b(1, 3, 7, 0, 0));      // faces 2 and 1
        send_ab(half_a(25, 1, 1, 0, 1), half_b(6, 0, 3, 3, 7));      // face 3
        send_ab(half_a(1, 2, 2, 1, 1), half_b(10, 2, 6, 1, 2));
        for (int i = 0; i < 4; i++)
            send_ab(half_a(4, i, 3 - i, i % 2, i / 2),
                    half_b(i * 5, i, 7 * (i % 2), 3 - i, 7 - 7 * (i % 2)));

        run_random(250, -1);

        // everything at maximum; limit field 63 acts as table size
        program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                     16'hFFFF, 1'b0);
        run_random(150, -1);

        // zero geometry, full table
        program_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd56, 1'b0);
        run_random(100, -1);

        // limit zero: every word rejected, time still runs
        program_regs(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                     16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                     16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                     16'hFFC0, 1'b0);
        run_random(40, -1);

        program_regs(16'($urandom_range(0, 8000)), 16'($urandom_range(0, 8000)),
                     16'($urandom_range(0, 8000)), 16'($urandom_range(0, 8000)),
                     16'($urandom_range(0, 8000)), 16'($urandom_range(0, 8000)),
                     16'd1, 1'b0);
        run_random(80, -1);

        // limit 56 with junk upper bits, a write to an unused index, and the
        // long sink hold-off partway through
        program_regs(16'($urandom_range(0, 8000)), 16'($urandom_range(0, 8000)),
                     16'($urandom_range(0, 8000)), 16'($urandom_range(0, 8000)),
                     16'($urandom_range(0, 8000)), 16'($urandom_range(0, 8000)),
                     16'hFFB8, 1'b1);
        run_random(200, 60);

        for (int j = 0; j < 3; j++)
        begin
            span = (j == 0) ? 65535 : 6000;
            program_regs(16'($urandom_range(0, span)), 16'($urandom_range(0, span)),
                         16'($urandom_range(0, span)), 16'($urandom_range(0, span)),
                         16'($urandom_range(0, span)), 16'($urandom_range(0, span)),
                         16'($urandom_range(1, 63)), 1'b0);
            run_random(150, -1);
        end

        // closing stretch at full rate on both sides
        program_regs(16'($urandom_range(0, 6000)), 16'($urandom_range(0, 6000)),
                     16'($urandom_range(0, 6000)), 16'($urandom_range(0, 6000)),
                     16'($urandom_range(0, 6000)), 16'($urandom_range(0, 6000)),
                     16'd56, 1'b0);
        calm <= 1'b1;
        run_random(180, -1);

        drain_results();
        repeat (6) @(posedge clk);

        $display("Covered %0d words over %0d register settings, incl. saturating, zero",
                 words_sent, settings_used);
        $display("and rejecting geometry, tag wrap, off-face buckets and a long sink stall.");
        if (fail_count == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
